### design/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the message stream deframer.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_DATA   = 2'd0,
    EV_EMPTY  = 2'd1,
    EV_SIGERR = 2'd2,
    EV_LENERR = 2'd3
  } event_e;

  // Register indexes, taken from the word address.
  typedef enum logic {
    REG_SIG_BYTE    = 1'b0,
    REG_MAX_PAYLOAD = 1'b1
  } reg_idx_e;

  localparam logic [ByteW-1:0] SigByteRst    = '0;
  localparam logic [LenW-1:0]  MaxPayloadRst = '1;

  typedef struct packed {
    logic [ByteW-1:0] sig_byte;
    logic [LenW-1:0]  max_payload;
  } cfg_t;

endpackage

### design/msd_regs.sv
// ----------------------------------------------------------------------------
// msd_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module msd_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msd_pkg::AddrW-1:0]   paddr,
  input  logic [msd_pkg::DataW-1:0]   pwdata,
  output logic [msd_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output msd_pkg::cfg_t               cfg_o
);
  import msd_pkg::*;

  logic [ByteW-1:0] sig_byte_q;
  logic [LenW-1:0]  max_payload_q;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_byte_q    <= SigByteRst;
      max_payload_q <= MaxPayloadRst;
    end else if (wr_en) begin
      case (idx)
        REG_SIG_BYTE:    sig_byte_q    <= pwdata[ByteW-1:0];
        REG_MAX_PAYLOAD: max_payload_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SIG_BYTE:    prdata = {{(DataW-ByteW){1'b0}}, sig_byte_q};
      REG_MAX_PAYLOAD: prdata = {{(DataW-LenW){1'b0}}, max_payload_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.sig_byte    = sig_byte_q;
  assign cfg_o.max_payload = max_payload_q;

endmodule

### design/msd_core.sv
// ----------------------------------------------------------------------------
// msd_core
// Input byte register, frame parser and result register.
// ----------------------------------------------------------------------------
module msd_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  msd_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [msd_pkg::ByteW-1:0] rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                event_res_o,
  output logic [msd_pkg::ByteW-1:0] msg_type_o,
  output logic [msd_pkg::ByteW-1:0] msg_flags_o,
  output logic [msd_pkg::LenW-1:0]  msg_length_o,
  output logic [msd_pkg::ByteW-1:0] data_byte_o,
  output logic                      last_of_message_o
);
  import msd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG     = 3'd0,
    PH_TYPE    = 3'd1,
    PH_FLAGS   = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DEAD    = 3'd6
  } phase_e;

  // Input register.
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;

  // Frame state.
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] held_type_q, held_type_d;
  logic [ByteW-1:0] held_flags_q, held_flags_d;
  logic [LenW-1:0]  held_len_q, held_len_d;
  logic [LenW-1:0]  left_q, left_d;

  // Result register.
  logic             out_vld_q;
  event_e           ev_q, ev_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] flags_q, flags_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [ByteW-1:0] data_q, data_d;
  logic             last_q, last_d;
  logic             res_d;

  logic             advance;
  logic             take;
  logic [LenW-1:0]  len_full;
  logic [LenW-1:0]  left_dec;

  // The parsed byte leaves the input register whenever the result register
  // is free or is being drained in this cycle.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign take       = in_valid_i && !in_stall_o;

  assign len_full = {held_len_q[LenW-1:ByteW], in_byte_q};
  assign left_dec = left_q - LenW'(1);

  always_comb begin
    phase_d      = phase_q;
    held_type_d  = held_type_q;
    held_flags_d = held_flags_q;
    held_len_d   = held_len_q;
    left_d       = left_q;
    res_d        = 1'b0;
    ev_d         = EV_DATA;
    type_d       = '0;
    flags_d      = '0;
    len_d        = '0;
    data_d       = '0;
    last_d       = 1'b0;
    case (phase_q)
      PH_SIG: begin
        if (in_byte_q != cfg_i.sig_byte) begin
          phase_d = PH_DEAD;
          res_d   = 1'b1;
          ev_d    = EV_SIGERR;
        end else begin
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        held_type_d = in_byte_q;
        phase_d     = PH_FLAGS;
      end
      PH_FLAGS: begin
        held_flags_d = in_byte_q;
        phase_d      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_len_d = {in_byte_q, {ByteW{1'b0}}};
        phase_d    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        held_len_d = len_full;
        type_d     = held_type_q;
        flags_d    = held_flags_q;
        if (len_full > cfg_i.max_payload) begin
          phase_d = PH_DEAD;
          res_d   = 1'b1;
          ev_d    = EV_LENERR;
          len_d   = len_full;
        end else if (len_full == '0) begin
          phase_d = PH_SIG;
          left_d  = '0;
          res_d   = 1'b1;
          ev_d    = EV_EMPTY;
          last_d  = 1'b1;
        end else begin
          left_d  = len_full;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        left_d  = left_dec;
        res_d   = 1'b1;
        ev_d    = EV_DATA;
        type_d  = held_type_q;
        flags_d = held_flags_q;
        len_d   = held_len_q;
        data_d  = in_byte_q;
        last_d  = (left_dec == '0);
        if (left_dec == '0) begin
          phase_d = PH_SIG;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      phase_q      <= PH_SIG;
      held_type_q  <= '0;
      held_flags_q <= '0;
      held_len_q   <= '0;
      left_q       <= '0;
    end else begin
      if (take) begin
        in_vld_q  <= 1'b1;
        in_byte_q <= rx_byte_i;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end

      if (advance) begin
        phase_q      <= phase_d;
        held_type_q  <= held_type_d;
        held_flags_q <= held_flags_d;
        held_len_q   <= held_len_d;
        left_q       <= left_d;
        out_vld_q    <= res_d;
        if (res_d) begin
          ev_q    <= ev_d;
          type_q  <= type_d;
          flags_q <= flags_d;
          len_q   <= len_d;
          data_q  <= data_d;
          last_q  <= last_d;
        end
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign event_res_o       = ev_q;
  assign msg_type_o        = type_q;
  assign msg_flags_o       = flags_q;
  assign msg_length_o      = len_q;
  assign data_byte_o       = data_q;
  assign last_of_message_o = last_q;

endmodule

### design/message_stream_deframer.sv
// ----------------------------------------------------------------------------
// message_stream_deframer
// Splits a byte stream into signature/type/flags/length framed messages.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock, unless in_stall_o holds it, and gives
// at most one transfer per byte: each payload byte tagged with its frame's type,
// flags and length, an empty-message event for a zero-length frame, or a single
// signature or length error after which all bytes are dropped until reset. A
// byte passes through an input register and the parser into the result
// register, which loads only while it is free or being drained. The sustained
// rate is one byte per cycle, limited only by downstream stall.
module message_stream_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [msd_pkg::AddrW-1:0] paddr,
  input  logic [msd_pkg::DataW-1:0] pwdata,
  output logic [msd_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [msd_pkg::ByteW-1:0] rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                event_res_o,
  output logic [msd_pkg::ByteW-1:0] msg_type_o,
  output logic [msd_pkg::ByteW-1:0] msg_flags_o,
  output logic [msd_pkg::LenW-1:0]  msg_length_o,
  output logic [msd_pkg::ByteW-1:0] data_byte_o,
  output logic                      last_of_message_o
);
  import msd_pkg::*;

  cfg_t cfg;

  msd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msd_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_res_o       (event_res_o),
    .msg_type_o        (msg_type_o),
    .msg_flags_o       (msg_flags_o),
    .msg_length_o      (msg_length_o),
    .data_byte_o       (data_byte_o),
    .last_of_message_o (last_of_message_o)
  );

endmodule

### verif/message_stream_deframer_tb.sv
// ----------------------------------------------------------------------------
// message_stream_deframer_tb
// Self-checking bench for the message stream deframer.
// ----------------------------------------------------------------------------
// Frames are fed in, malformed only at the end, and every accepted byte is run
// through a behavioral parser kept in this bench. The events the parser
// produces are queued and compared field by field with each output transfer.
// The run goes through a short directed part, a frame whose length equals the
// limit, a long downstream hold-off, four random phases with different
// register settings and idle rates, and ends with a single framing error
// followed by bytes that must all be dropped.
// ----------------------------------------------------------------------------
module message_stream_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  typedef enum logic [2:0] {
    PS_SIG,
    PS_TYPE,
    PS_FLAGS,
    PS_LEN_HI,
    PS_LEN_LO,
    PS_PAYLOAD,
    PS_DEAD
  } parse_state_e;

  typedef struct {
    event_e           ev;
    logic [ByteW-1:0] msg_type;
    logic [ByteW-1:0] msg_flags;
    logic [LenW-1:0]  msg_length;
    logic [ByteW-1:0] data_byte;
    logic             last;
  } frame_event_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [AddrW-1:0]  paddr       = '0;
  logic [DataW-1:0]  pwdata      = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [ByteW-1:0]  rx_byte_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        event_res_o;
  logic [ByteW-1:0]  msg_type_o;
  logic [ByteW-1:0]  msg_flags_o;
  logic [LenW-1:0]   msg_length_o;
  logic [ByteW-1:0]  data_byte_o;
  logic              last_of_message_o;

  // Parser state and register copies of the bench.
  frame_event_t      pending_events[$];
  parse_state_e      parse_state   = PS_SIG;
  logic [ByteW-1:0]  held_type_q   = '0;
  logic [ByteW-1:0]  held_flags_q  = '0;
  logic [LenW-1:0]   held_len_q    = '0;
  logic [LenW-1:0]   remaining_q   = '0;
  logic [ByteW-1:0]  sig_cfg       = SigByteRst;
  logic [LenW-1:0]   max_len_cfg   = MaxPayloadRst;

  int unsigned       send_idle_pct     = 0;
  int unsigned       recv_stall_pct    = 0;
  int unsigned       stall_hold_cycles = 0;
  int unsigned       mismatches        = 0;

  message_stream_deframer u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_res_o       (event_res_o),
    .msg_type_o        (msg_type_o),
    .msg_flags_o       (msg_flags_o),
    .msg_length_o      (msg_length_o),
    .data_byte_o       (data_byte_o),
    .last_of_message_o (last_of_message_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Advances the parser by one accepted byte and queues the event it causes.
  function automatic void predict_byte(input logic [ByteW-1:0] b);
    frame_event_t e;
    e.ev         = EV_DATA;
    e.msg_type   = '0;
    e.msg_flags  = '0;
    e.msg_length = '0;
    e.data_byte  = '0;
    e.last       = 1'b0;
    case (parse_state)
      PS_SIG: begin
        if (b != sig_cfg) begin
          parse_state = PS_DEAD;
          e.ev = EV_SIGERR;
          pending_events.insert(pending_events.size(), e);
        end else begin
          parse_state = PS_TYPE;
        end
      end
      PS_TYPE: begin
        held_type_q = b;
        parse_state = PS_FLAGS;
      end
      PS_FLAGS: begin
        held_flags_q = b;
        parse_state  = PS_LEN_HI;
      end
      PS_LEN_HI: begin
        held_len_q  = {b, 8'h00};
        parse_state = PS_LEN_LO;
      end
      PS_LEN_LO: begin
        held_len_q  = {held_len_q[15:8], b};
        e.msg_type  = held_type_q;
        e.msg_flags = held_flags_q;
        if (held_len_q > max_len_cfg) begin
          parse_state  = PS_DEAD;
          e.ev         = EV_LENERR;
          e.msg_length = held_len_q;
          pending_events.insert(pending_events.size(), e);
        end else if (held_len_q == '0) begin
          parse_state = PS_SIG;
          remaining_q = '0;
          e.ev        = EV_EMPTY;
          e.last      = 1'b1;
          pending_events.insert(pending_events.size(), e);
        end else begin
          remaining_q = held_len_q;
          parse_state = PS_PAYLOAD;
        end
      end
      PS_PAYLOAD: begin
        remaining_q  = remaining_q - 16'd1;
        e.msg_type   = held_type_q;
        e.msg_flags  = held_flags_q;
        e.msg_length = held_len_q;
        e.data_byte  = b;
        e.last       = (remaining_q == '0);
        if (e.last) begin
          parse_state = PS_SIG;
        end
        pending_events.insert(pending_events.size(), e);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [LenW-1:0] exp_v,
                                      input logic [LenW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Receiver stall: a counted hold-off when requested, random otherwise.
  always @(posedge clk_i) begin
    if (stall_hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      stall_hold_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Outputs are stable at the falling edge, so a transfer seen here happens
  // at the next rising edge.
  always @(negedge clk_i) begin
    frame_event_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual event %0d data %0h",
                 $time, event_res_o, data_byte_o);
        mismatches++;
      end else begin
        e = pending_events[0];
        pending_events.delete(0);
        check_field("event_res", LenW'(e.ev), LenW'(event_res_o));
        check_field("msg_type", LenW'(e.msg_type), LenW'(msg_type_o));
        check_field("msg_flags", LenW'(e.msg_flags), LenW'(msg_flags_o));
        check_field("msg_length", e.msg_length, msg_length_o);
        check_field("data_byte", LenW'(e.data_byte), LenW'(data_byte_o));
        check_field("last_of_message", LenW'(e.last), LenW'(last_of_message_o));
      end
    end
  end

  // Called and returns at a rising edge; valid stays high after the transfer.
  task automatic send_byte(input logic [ByteW-1:0] b);
    bit taken = 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) begin
        predict_byte(b);
      end
      @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input logic [ByteW-1:0] ftype, input logic [ByteW-1:0] fflags,
                            input logic [LenW-1:0] flen);
    send_byte(sig_cfg);
    send_byte(ftype);
    send_byte(fflags);
    send_byte(flen[15:8]);
    send_byte(flen[7:0]);
    for (int i = 0; i < flen; i++) begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Stops sending and waits for every queued event, then lets the pipeline settle.
  task automatic wait_drained();
    int guard = 0;
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_events.size() != 0) begin
      $display("%0t: %0d expected transfers never arrived, expected 0, actual %0d",
               $time, pending_events.size(), pending_events.size());
      mismatches++;
      pending_events.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SIG_BYTE:    sig_cfg     = value[ByteW-1:0];
      REG_MAX_PAYLOAD: max_len_cfg = value[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Empty message with the reset signature.
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    // One payload byte, which is also the last one.
    send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h01);
    send_byte(8'hFF);
    // Register writes inside a frame: the new signature only applies to the next
    // frame, and the new limit applies at this frame's length check.
    send_byte(8'h00);
    wait_drained();
    write_reg(REG_SIG_BYTE, 32'hA5);
    send_byte(8'h5A); send_byte(8'h3C); send_byte(8'h00);
    wait_drained();
    write_reg(REG_MAX_PAYLOAD, 32'd3);
    send_byte(8'h03); send_byte(8'h00); send_byte(8'h80); send_byte(8'h7F);
    send_byte(8'hA5); send_byte(8'h01); send_byte(8'h02); send_byte(8'h00); send_byte(8'h00);
    wait_drained();
    write_reg(REG_MAX_PAYLOAD, 32'hFFFF);
  endtask

  // A frame whose length equals the configured limit is still accepted.
  task automatic test_max_length();
    logic [LenW-1:0] limit_len;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    limit_len = 16'($urandom_range(16, 48));
    write_reg(REG_MAX_PAYLOAD, 32'(limit_len));
    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), limit_len);
    wait_drained();
    write_reg(REG_MAX_PAYLOAD, 32'hFFFF);
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    stall_hold_cycles = 200;
    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd100);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                             input logic [ByteW-1:0] sig, input logic [LenW-1:0] max_len,
                             input int unsigned byte_budget);
    int unsigned sent = 0;
    int unsigned len;
    int unsigned pick;
    write_reg(REG_SIG_BYTE, 32'(sig));
    write_reg(REG_MAX_PAYLOAD, 32'(max_len));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < byte_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(0, 8);
      end else if (pick < 95) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(200, 300);
      end
      if (len > max_len_cfg) begin
        len = $urandom_range(0, max_len_cfg);
      end
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
      sent += len + 5;
    end
    wait_drained();
  endtask

  // Only one error fits in a run, since the block stays dead until reset.
  task automatic test_error_then_drop();
    logic [LenW-1:0] limit_len;
    logic [LenW-1:0] bad_len;
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    if ($urandom_range(0, 1) == 1) begin
      limit_len = 16'($urandom_range(0, 65534));
      write_reg(REG_MAX_PAYLOAD, 32'(limit_len));
      bad_len = 16'($urandom_range(limit_len + 1, 65535));
      send_byte(sig_cfg);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
      send_byte(bad_len[15:8]);
      send_byte(bad_len[7:0]);
    end else begin
      send_byte(sig_cfg ^ 8'($urandom_range(1, 255)));
    end
    // Everything after the error must be dropped, valid frames included.
    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd4);
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_max_length();
    test_backpressure();
    test_random(0, 0, 8'hFF, 16'hFFFF, 170);
    test_random(48, 0, 8'h00, 16'h0000, 170);
    test_random(0, 48, 8'($urandom_range(0, 255)), 16'($urandom_range(1, 300)), 170);
    test_random(37, 37, 8'($urandom_range(0, 255)), 16'hFFFF, 170);
    test_error_then_drop();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### message_stream_deframer.f
design/msd_pkg.sv
design/msd_regs.sv
design/msd_core.sv
design/message_stream_deframer.sv
verif/message_stream_deframer_tb.sv
